FILE: hdl/pls_pkg.sv
package pls_pkg;

  // Number of list cells.
  localparam int unsigned CAPACITY = 16;
  // Most results that one listing transaction delivers.
  localparam int unsigned MAX_RESULTS = 16;

  // Width of a count of stored entries (0 .. CAPACITY).
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Width that holds both a count and the result limit.
  localparam int unsigned LIM_W = (CNT_W > $clog2(MAX_RESULTS + 1)) ?
                                  CNT_W : $clog2(MAX_RESULTS + 1);
  // Width that holds both a count and an input position.
  localparam int unsigned POS_IN_W = 5;
  localparam int unsigned CMP_W = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LIST   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_REMOVE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    cnt_t     cnt;
    cnt_t     pos;
    value_t   value;
  } cell_ctrl_t;

endpackage

FILE: hdl/pls_cell.sv
module pls_cell (
  input  logic                clk_i,
  input  pls_pkg::cell_ctrl_t ctrl_i,
  input  pls_pkg::cnt_t       idx_i,
  input  pls_pkg::value_t     left_i,
  input  pls_pkg::value_t     right_i,
  input  pls_pkg::value_t     head_i,
  output pls_pkg::value_t     data_o
);

  pls_pkg::value_t data_q;
  pls_pkg::value_t data_d;
  pls_pkg::cnt_t   idx_next;

  assign idx_next = idx_i + pls_pkg::cnt_t'(1);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      pls_pkg::CELL_APPEND: begin
        if (idx_i == ctrl_i.cnt) data_d = ctrl_i.value;
      end
      pls_pkg::CELL_INSERT: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if ((idx_i > ctrl_i.pos) && (idx_i <= ctrl_i.cnt)) begin
          data_d = left_i;
        end
      end
      pls_pkg::CELL_REMOVE: begin
        if ((idx_i >= ctrl_i.pos) && (idx_next < ctrl_i.cnt)) data_d = right_i;
      end
      pls_pkg::CELL_ROTATE: begin
        // The head entry wraps around to the tail of the occupied part.
        if (idx_next < ctrl_i.cnt) begin
          data_d = right_i;
        end else if (idx_next == ctrl_i.cnt) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hdl/positional_list_store.sv
// Ordered list store of signed 32-bit entries kept in a chain of cells.
// Input channel s_axis: tuser carries the mode (append, insert, remove, list),
// tdata carries the value and the position. Output channel m_axis: tuser is
// the status, tdata the entry value and the entry count, tlast marks the final
// result of an input transaction.
// Append, insert and remove deliver one result through the output register
// in the cycle after acceptance; a new input transaction is taken in every cycle
// while the receiver keeps up. Insert and remove shift the cells from the given
// position onward in the same cycle. Listing rotates the chain by one cell per
// cycle while the receiver keeps up and emits the head cell; no input is taken
// during a listing, and the rotation restores the original order at its end.
// Reset clears the entry count, the listing state and the output valid flag; the
// cell contents are not cleared, since only occupied cells are ever read.
// When the receiver stalls, the result waits in the output register and the
// chain pauses, and an input is taken only when the output register is free
// or being emptied in the same cycle.
module positional_list_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value [31:0], position [36:32], zeros
  input  logic [1:0]  s_axis_tuser,  // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // entry_value [31:0], entry_count [36:32], zeros
  output logic [1:0]  m_axis_tuser,  // status [1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned N = pls_pkg::CAPACITY;

  // Control state.
  pls_pkg::cnt_t   count_q, count_d;
  logic            list_q, list_d;
  pls_pkg::cnt_t   list_idx_q, list_idx_d;
  logic            out_valid_q, out_valid_d;

  // Output payload.
  pls_pkg::status_e out_status_q, out_status_d;
  pls_pkg::value_t  out_value_q, out_value_d;
  logic             out_last_q, out_last_d;
  pls_pkg::cnt_t    out_count_q, out_count_d;

  pls_pkg::cell_ctrl_t cell_ctrl;
  pls_pkg::value_t     cell_data [N];

  logic                     out_free;
  logic                     in_accept;
  pls_pkg::mode_e           in_mode;
  pls_pkg::value_t          in_value;
  logic [pls_pkg::CMP_W-1:0] in_pos_w;
  logic [pls_pkg::CMP_W-1:0] count_w;
  logic                     is_full;
  logic [pls_pkg::LIM_W-1:0] list_n;
  logic [pls_pkg::LIM_W-1:0] list_idx_w;
  pls_pkg::cnt_t            list_idx_next;

  assign in_mode  = pls_pkg::mode_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[31:0];
  assign in_pos_w = pls_pkg::CMP_W'(s_axis_tdata[36:32]);
  assign count_w  = pls_pkg::CMP_W'(count_q);
  assign is_full  = (count_q == pls_pkg::cnt_t'(N));

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !list_q && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Number of entries a listing emits, limited to the result limit.
  assign list_n = (pls_pkg::LIM_W'(count_q) > pls_pkg::LIM_W'(pls_pkg::MAX_RESULTS)) ?
                  pls_pkg::LIM_W'(pls_pkg::MAX_RESULTS) : pls_pkg::LIM_W'(count_q);
  assign list_idx_w    = pls_pkg::LIM_W'(list_idx_q);
  assign list_idx_next = list_idx_q + pls_pkg::cnt_t'(1);

  always_comb begin
    count_d      = count_q;
    list_d       = list_q;
    list_idx_d   = list_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_count_d  = out_count_q;

    cell_ctrl.op    = pls_pkg::CELL_HOLD;
    cell_ctrl.cnt   = count_q;
    cell_ctrl.pos   = pls_pkg::cnt_t'(in_pos_w);
    cell_ctrl.value = in_value;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    if (list_q && out_free) begin
      // One rotation step; emit the head cell while under the result limit.
      cell_ctrl.op = pls_pkg::CELL_ROTATE;
      list_idx_d   = list_idx_next;
      if (list_idx_next == count_q) list_d = 1'b0;
      if (list_idx_w < list_n) begin
        out_valid_d  = 1'b1;
        out_status_d = pls_pkg::ST_OK;
        out_value_d  = cell_data[0];
        out_count_d  = count_q;
        out_last_d   = ((list_idx_w + pls_pkg::LIM_W'(1)) == list_n);
      end
    end else if (in_accept) begin
      out_status_d = pls_pkg::ST_OK;
      out_value_d  = '0;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      case (in_mode)
        pls_pkg::MODE_APPEND: begin
          if (is_full) begin
            out_status_d = pls_pkg::ST_FULL;
          end else begin
            cell_ctrl.op = pls_pkg::CELL_APPEND;
            count_d      = count_q + pls_pkg::cnt_t'(1);
          end
        end
        pls_pkg::MODE_INSERT: begin
          if (in_pos_w > count_w) begin
            out_status_d = pls_pkg::ST_RANGE;
          end else if (is_full) begin
            out_status_d = pls_pkg::ST_FULL;
          end else begin
            cell_ctrl.op = pls_pkg::CELL_INSERT;
            count_d      = count_q + pls_pkg::cnt_t'(1);
          end
        end
        pls_pkg::MODE_REMOVE: begin
          if (in_pos_w >= count_w) begin
            out_status_d = pls_pkg::ST_RANGE;
          end else begin
            cell_ctrl.op = pls_pkg::CELL_REMOVE;
            count_d      = count_q - pls_pkg::cnt_t'(1);
          end
        end
        default: begin
          // Listing: an empty list answers at once, otherwise start rotating.
          if (count_q == '0) begin
            out_status_d = pls_pkg::ST_EMPTY;
          end else begin
            out_valid_d = 1'b0;
            list_d      = 1'b1;
            list_idx_d  = '0;
          end
        end
      endcase
      out_count_d = count_d;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    pls_pkg::value_t left_data;
    pls_pkg::value_t right_data;
    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[g+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .idx_i   (pls_pkg::cnt_t'(g)),
      .left_i  (left_data),
      .right_i (right_data),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      list_q      <= 1'b0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      list_q      <= list_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, pls_pkg::COUNT_OUT_W'(out_count_q), out_value_q};

  // No input is taken while a listing rotates the chain.
  a_list_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_q |-> !s_axis_tready)
    else $error("input accepted during listing");

  // The entry count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pls_pkg::cnt_t'(N))
    else $error("entry count beyond capacity");

  // A non-final result, which only a listing gives, carries the OK status.
  a_not_last_is_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_status_q == pls_pkg::ST_OK))
    else $error("non-final result with error status");

  // The count does not change while a listing is in progress.
  a_count_stable_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (list_q && $past(list_q)) |-> $stable(count_q))
    else $error("entry count changed during listing");

endmodule
